// File: hw/rtl/jfkx_pkg.sv
`default_nettype none

package jfkx_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int VALUE_WIDTH  = 32;

  localparam logic [2:0] KIND_NUM1     = 3'd0;
  localparam logic [2:0] KIND_NUM2     = 3'd1;
  localparam logic [2:0] KIND_MSG_CHAR = 3'd2;
  localparam logic [2:0] KIND_MSG_END  = 3'd3;
  localparam logic [2:0] KIND_BOOL     = 3'd4;
  localparam logic [2:0] KIND_BODY_END = 3'd5;

  localparam logic [7:0] MAX_MSG_RESET = 8'd31;

  // Key text, indexed by key then by character position.
  localparam logic [7:0] KEY_TEXT [4][4] = '{
    '{8'h6e, 8'h75, 8'h6d, 8'h31},
    '{8'h6e, 8'h75, 8'h6d, 8'h32},
    '{8'h6d, 8'h73, 8'h67, 8'h00},
    '{8'h62, 8'h6f, 8'h6f, 8'h6c}
  };
  localparam logic [2:0] KEY_LEN [4] = '{3'd4, 3'd4, 3'd3, 3'd4};

  typedef struct packed {
    logic [2:0]             kind;
    logic [VALUE_WIDTH-1:0] value;
    logic                   body_end;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_pair_t;

  function automatic res_t make_res(input logic [2:0] kind,
                                    input logic [VALUE_WIDTH-1:0] value,
                                    input logic body_end);
    res_t r;
    r.kind     = kind;
    r.value    = value;
    r.body_end = body_end;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/json_fixed_key_field_extractor.sv
// Extracts fixed keys from a flat JSON body arriving one byte per item.
// Input channel: in_valid, in_stall, in_byte. A byte is taken at a clock edge
// where in_valid is high and in_stall is low.
// Result channel: out_valid, out_stall, out_field_kind, out_field_value and
// out_body_end. A result is taken where out_valid is high and out_stall low.
// Configuration: cfg_valid, cfg_ready, cfg_data write the message length
// limit; cfg_ready is always high, and writes belong between bodies.
// A byte taken is held in byte_r and parsed from there; its results are
// written into the result queue and offered from its head.
// Throughput: one byte per cycle while in_stall is low. Results leave one per
// cycle; a byte that closes a value and the body gives two results, and the
// queue takes the extra one, so with the receiver ready the input never waits.
// A four-entry result queue decouples the sides, so bytes keep flowing while
// a finished result waits. When the receiver stalls, the queue fills and
// in_stall rises once fewer than two entries are free; nothing is lost.
// Reset clears the parser to wait for an opening brace, empties the queue
// and sets the message limit to 31 characters.
`default_nettype none

module json_fixed_key_field_extractor
  import jfkx_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  out_field_kind,
  output logic [VALUE_WIDTH-1:0]      out_field_value,
  output logic                        out_body_end,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [7:0]             cfg_data
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       step;
  logic       in_take;
  logic       out_take;
  logic [2:0] q_fill;
  res_pair_t  results;
  res_t       head;

  assign cfg_ready = 1'b1;
  assign step      = vld_r && (q_fill <= 3'd2);
  assign in_stall  = vld_r && !step;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  assign out_field_kind  = head.kind;
  assign out_field_value = head.value;
  assign out_body_end    = head.body_end;

  always_comb begin
    vld_nxt = vld_r;
    if (in_take) begin
      vld_nxt = 1'b1;
    end else if (step) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte;
    end
  end

  jfkx_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .byte_in  (byte_r),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .results  (results)
  );

  jfkx_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (results),
    .pop       (out_take),
    .head      (head),
    .not_empty (out_valid),
    .fill      (q_fill)
  );

  a_body_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_body_end |-> out_field_kind == KIND_BODY_END)
    else $error("Body-end flag on a result that is not a body end.");

  a_msg_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_kind == KIND_MSG_END |-> out_field_value == '0)
    else $error("Message-end result carries a non-zero value.");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_fill >= 3'd3 && vld_r)
    else $error("Input held back while the result queue has room.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result offered straight after reset.");

endmodule

`default_nettype wire

// File: hw/rtl/jfkx_parser.sv
`default_nettype none

module jfkx_parser
  import jfkx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  output res_pair_t       results
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SCAN    = 3'd1;
  localparam logic [2:0] PH_KEY     = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_SEP     = 3'd4;
  localparam logic [2:0] PH_NUMBER  = 3'd5;
  localparam logic [2:0] PH_MESSAGE = 3'd6;
  localparam logic [2:0] PH_BOOLEAN = 3'd7;

  localparam logic [3:0] K_MSG  = 4'b0100;
  localparam logic [3:0] K_BOOL = 4'b1000;
  localparam logic [3:0] K_NUM2 = 4'b0010;

  localparam logic [7:0] CH_OPEN  = 8'h7b;
  localparam logic [7:0] CH_CLOSE = 8'h7d;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TRUE  = 8'h74;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  logic [2:0]              phase_r, phase_nxt;
  logic [1:0]              pos_r, pos_nxt;
  logic [3:0]              cand_r, cand_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic [7:0]              cnt_r, cnt_nxt;
  logic [7:0]              max_len_r;

  logic [3:0]              match;
  logic [3:0]              done;
  logic [3:0]              done_onehot;
  logic [NUMBER_WIDTH-1:0] byte_ext;
  logic [NUMBER_WIDTH-1:0] acc_fold;
  logic [NUMBER_WIDTH-1:0] acc_first;
  logic [2:0]              num_kind;
  logic                    can_emit;
  res_t                    body_res;
  res_t                    char_res;

  assign byte_ext  = {{(NUMBER_WIDTH-8){1'b0}}, byte_in};
  assign acc_fold  = (acc_r << 3) + (acc_r << 1) + byte_ext
                     - {{(NUMBER_WIDTH-8){1'b0}}, CH_ZERO};
  assign acc_first = byte_ext - {{(NUMBER_WIDTH-8){1'b0}}, CH_ZERO};
  assign num_kind  = (cand_r == K_NUM2) ? KIND_NUM2 : KIND_NUM1;
  assign can_emit  = cnt_r < max_len_r;
  assign body_res  = make_res(KIND_BODY_END, '0, 1'b1);
  assign char_res  = make_res(KIND_MSG_CHAR, {{(VALUE_WIDTH-8){1'b0}}, byte_in}, 1'b0);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      match[k] = cand_r[k] && ({1'b0, pos_r} < KEY_LEN[k]) &&
                 (KEY_TEXT[k][pos_r] == byte_in);
      done[k]  = match[k] && (KEY_LEN[k] == {1'b0, pos_r} + 3'd1);
    end
    done_onehot = '0;
    for (int k = 3; k >= 0; k--) begin
      if (done[k]) begin
        done_onehot = 4'(1 << k);
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    cand_nxt       = cand_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    results.count  = 2'd0;
    results.first  = body_res;
    results.second = body_res;

    if (phase_r == PH_IDLE) begin
      if (byte_in == CH_OPEN) begin
        phase_nxt = PH_SCAN;
        pos_nxt   = '0;
        cand_nxt  = '0;
        acc_nxt   = '0;
        cnt_nxt   = '0;
      end
    end else if (phase_r == PH_MESSAGE) begin
      if (byte_in == CH_QUOTE) begin
        results.count = 2'd1;
        results.first = make_res(KIND_MSG_END, '0, 1'b0);
        phase_nxt     = PH_SCAN;
      end else if (can_emit) begin
        results.count = 2'd1;
        results.first = char_res;
        cnt_nxt       = cnt_r + 8'd1;
      end
    end else if (byte_in == CH_OPEN) begin
      phase_nxt = PH_SCAN;
      pos_nxt   = '0;
      cand_nxt  = '0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE, PH_MESSAGE: begin
        end
        PH_SCAN, PH_KEY: begin
          if (phase_r == PH_KEY && match != 4'b0000) begin
            if (done != 4'b0000) begin
              cand_nxt  = done_onehot;
              pos_nxt   = '0;
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_SKIP;
            end else begin
              cand_nxt = match;
              pos_nxt  = pos_r + 2'd1;
            end
          end else begin
            // A broken key match falls back to scanning the same byte.
            phase_nxt = PH_SCAN;
            if (byte_in == CH_QUOTE) begin
              phase_nxt = PH_KEY;
              pos_nxt   = '0;
              cand_nxt  = 4'hf;
            end else if (byte_in == CH_CLOSE) begin
              results.count = 2'd1;
              phase_nxt     = PH_IDLE;
              pos_nxt       = '0;
              cand_nxt      = '0;
              acc_nxt       = '0;
              cnt_nxt       = '0;
            end
          end
        end
        PH_SKIP: begin
          if (byte_in == CH_CLOSE) begin
            results.count = 2'd1;
            phase_nxt     = PH_IDLE;
            pos_nxt       = '0;
            cand_nxt      = '0;
            acc_nxt       = '0;
            cnt_nxt       = '0;
          end else begin
            phase_nxt = PH_SEP;
          end
        end
        PH_SEP: begin
          if (byte_in == CH_COLON || byte_in == CH_SPACE) begin
          end else if (cand_r == K_MSG) begin
            if (byte_in == CH_QUOTE) begin
            end else if (byte_in == CH_CLOSE) begin
              results.count = 2'd1;
              phase_nxt     = PH_IDLE;
              pos_nxt       = '0;
              cand_nxt      = '0;
              acc_nxt       = '0;
              cnt_nxt       = '0;
            end else begin
              phase_nxt = PH_MESSAGE;
              if (can_emit) begin
                results.count = 2'd1;
                results.first = char_res;
                cnt_nxt       = cnt_r + 8'd1;
              end
            end
          end else if (cand_r == K_BOOL) begin
            acc_nxt   = {{(NUMBER_WIDTH-1){1'b0}}, byte_in == CH_TRUE};
            phase_nxt = PH_BOOLEAN;
            if (byte_in == CH_COMMA || byte_in == CH_CLOSE) begin
              results.count = 2'd1;
              results.first = make_res(KIND_BOOL, '0, 1'b0);
              phase_nxt     = PH_SCAN;
              if (byte_in == CH_CLOSE) begin
                results.count = 2'd2;
                phase_nxt     = PH_IDLE;
                pos_nxt       = '0;
                cand_nxt      = '0;
                acc_nxt       = '0;
                cnt_nxt       = '0;
              end
            end
          end else begin
            phase_nxt = PH_NUMBER;
            acc_nxt   = acc_first;
            if (byte_in == CH_COMMA || byte_in == CH_CLOSE) begin
              acc_nxt       = '0;
              results.count = 2'd1;
              results.first = make_res(num_kind, '0, 1'b0);
              phase_nxt     = PH_SCAN;
              if (byte_in == CH_CLOSE) begin
                results.count = 2'd2;
                phase_nxt     = PH_IDLE;
                pos_nxt       = '0;
                cand_nxt      = '0;
                cnt_nxt       = '0;
              end
            end
          end
        end
        PH_NUMBER, PH_BOOLEAN: begin
          if (byte_in == CH_COMMA || byte_in == CH_CLOSE) begin
            results.count = 2'd1;
            results.first = make_res((phase_r == PH_NUMBER) ? num_kind : KIND_BOOL,
                                     VALUE_WIDTH'(acc_r), 1'b0);
            phase_nxt     = PH_SCAN;
            if (byte_in == CH_CLOSE) begin
              results.count = 2'd2;
              phase_nxt     = PH_IDLE;
              pos_nxt       = '0;
              cand_nxt      = '0;
              acc_nxt       = '0;
              cnt_nxt       = '0;
            end
          end else if (phase_r == PH_NUMBER) begin
            acc_nxt = acc_fold;
          end
        end
      endcase
    end

    if (!step) begin
      results.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      cand_r    <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      max_len_r <= MAX_MSG_RESET;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        cand_r  <= cand_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_we) begin
        max_len_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/jfkx_result_queue.sv
`default_nettype none

module jfkx_result_queue
  import jfkx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire res_pair_t  push,
  input  wire logic       pop,
  output res_t            head,
  output logic            not_empty,
  output logic [2:0]      fill
);

  res_t       q_r [4];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] tail_next_slot;

  assign tail_next_slot = tail_r + 2'd1;
  assign head           = q_r[head_r];
  assign not_empty      = count_r != 3'd0;
  assign fill           = count_r;

  always_comb begin
    head_nxt  = head_r + {1'b0, pop};
    tail_nxt  = tail_r + push.count;
    count_nxt = count_r + {1'b0, push.count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[tail_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      q_r[tail_next_slot] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: verif/json_fixed_key_field_extractor_tb.sv
`default_nettype none

module json_fixed_key_field_extractor_tb;
  import jfkx_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASES       = 6;
  localparam int MAX_GAP      = 17;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 1000;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TRUE  = 8'h74;

  localparam logic [3:0] KEY_NUM2 = 4'b0010;
  localparam logic [3:0] KEY_MSG  = 4'b0100;
  localparam logic [3:0] KEY_BOOL = 4'b1000;

  typedef enum logic [3:0] {
    WAIT_OPEN, SCAN, KEY_MATCH, KEY_TAIL, SEPARATOR, NUMBER, MESSAGE, BOOLEAN
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } dir_row_t;

  localparam res_t NO_RES = '0;
  localparam int DIR_ROWS = 30;

  localparam dir_row_t DIRECTED_BYTES [DIR_ROWS] = '{
    '{8'hFF,    1'b1, 2'd0, NO_RES, NO_RES},
    '{8'h00,    1'b1, 2'd0, NO_RES, NO_RES},
    '{"{",      1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{"n",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"u",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"m",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"2",      1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{":",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"9",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"}",      1'b1, 2'd2, '{KIND_NUM2, 32'd9, 1'b0}, '{KIND_BODY_END, 32'd0, 1'b1}},
    '{"{",      1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{"m",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"s",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"g",      1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{"x",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"}",      1'b1, 2'd1, '{KIND_MSG_CHAR, 32'h7D, 1'b0}, NO_RES},
    '{CH_QUOTE, 1'b1, 2'd1, '{KIND_MSG_END, 32'd0, 1'b0}, NO_RES},
    '{CH_QUOTE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{"b",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"o",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"o",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"l",      1'b0, 2'd0, NO_RES, NO_RES},
    '{CH_QUOTE, 1'b0, 2'd0, NO_RES, NO_RES},
    '{"t",      1'b0, 2'd0, NO_RES, NO_RES},
    '{"}",      1'b1, 2'd2, '{KIND_BOOL, 32'd1, 1'b0}, '{KIND_BODY_END, 32'd0, 1'b1}}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [2:0]             out_field_kind;
  logic [VALUE_WIDTH-1:0] out_field_value;
  logic                   out_body_end;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [7:0]             cfg_data;

  json_fixed_key_field_extractor DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_kind  (out_field_kind),
    .out_field_value (out_field_value),
    .out_body_end    (out_body_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  parse_phase_t            phase;
  logic [2:0]              key_pos;
  logic [3:0]              key_set;
  logic [NUMBER_WIDTH-1:0] acc;
  logic [7:0]              msg_count;
  logic [7:0]              msg_limit;

  res_t       fields_due[$];
  logic [7:0] body_bytes[$];
  int         fields_pushed;
  int         items_sent;
  int         failures;
  int         quiet_cycles;
  bit         in_jitter;
  bit         out_jitter;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_field(input logic [2:0] kind, input logic [VALUE_WIDTH-1:0] value,
                                     input logic last);
    res_t r;
    r.kind     = kind;
    r.value    = value;
    r.body_end = last;
    fields_due.push_back(r);
    fields_pushed++;
  endfunction

  function automatic void clear_parse(input parse_phase_t next_phase);
    phase     = next_phase;
    key_pos   = '0;
    key_set   = '0;
    acc       = '0;
    msg_count = '0;
  endfunction

  function automatic void close_body();
    push_field(KIND_BODY_END, '0, 1'b1);
    clear_parse(WAIT_OPEN);
  endfunction

  function automatic void message_char(input logic [7:0] b);
    if (msg_count < msg_limit) begin
      push_field(KIND_MSG_CHAR, VALUE_WIDTH'(b), 1'b0);
      msg_count++;
    end
  endfunction

  function automatic void number_byte(input logic [7:0] b);
    logic [2:0] kind;
    kind = (key_set == KEY_NUM2) ? KIND_NUM2 : KIND_NUM1;
    if (b == CH_COMMA) begin
      push_field(kind, VALUE_WIDTH'(acc), 1'b0);
      phase = SCAN;
    end else if (b == CH_CLOSE) begin
      push_field(kind, VALUE_WIDTH'(acc), 1'b0);
      close_body();
    end else begin
      acc = acc * 10 + NUMBER_WIDTH'(b) - NUMBER_WIDTH'(CH_ZERO);
    end
  endfunction

  function automatic void boolean_byte(input logic [7:0] b);
    if (b == CH_COMMA) begin
      push_field(KIND_BOOL, VALUE_WIDTH'(acc), 1'b0);
      phase = SCAN;
    end else if (b == CH_CLOSE) begin
      push_field(KIND_BOOL, VALUE_WIDTH'(acc), 1'b0);
      close_body();
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    if (b == CH_QUOTE) begin
      phase   = KEY_MATCH;
      key_pos = '0;
      key_set = 4'hF;
    end else if (b == CH_CLOSE) begin
      close_body();
    end
  endfunction

  function automatic void extract_fields(input logic [7:0] b);
    logic [3:0] hit;
    bit         done;
    if (phase == WAIT_OPEN) begin
      if (b == CH_OPEN) clear_parse(SCAN);
    end else if (phase == MESSAGE) begin
      if (b == CH_QUOTE) begin
        push_field(KIND_MSG_END, '0, 1'b0);
        phase = SCAN;
      end else begin
        message_char(b);
      end
    end else if (b == CH_OPEN) begin
      clear_parse(SCAN);
    end else begin
      case (phase)
        SCAN: scan_byte(b);
        KEY_MATCH: begin
          hit = '0;
          for (int k = 0; k < 4; k++) begin
            if (key_set[k] && key_pos < KEY_LEN[k] && KEY_TEXT[k][key_pos[1:0]] == b) hit[k] = 1'b1;
          end
          if (hit == '0) begin
            phase = SCAN;
            scan_byte(b);
          end else begin
            done = 1'b0;
            for (int k = 0; k < 4; k++) begin
              if (!done && hit[k] && KEY_LEN[k] == key_pos + 3'd1) begin
                key_set   = 4'(1 << k);
                key_pos   = '0;
                acc       = '0;
                msg_count = '0;
                phase     = KEY_TAIL;
                done      = 1'b1;
              end
            end
            if (!done) begin
              key_set = hit;
              key_pos = key_pos + 3'd1;
            end
          end
        end
        KEY_TAIL: begin
          if (b == CH_CLOSE) close_body();
          else phase = SEPARATOR;
        end
        SEPARATOR: begin
          if (b != CH_COLON && b != CH_SPACE) begin
            if (key_set == KEY_MSG) begin
              if (b == CH_CLOSE) begin
                close_body();
              end else if (b != CH_QUOTE) begin
                phase = MESSAGE;
                message_char(b);
              end
            end else if (key_set == KEY_BOOL) begin
              acc   = (b == CH_TRUE) ? NUMBER_WIDTH'(1) : '0;
              phase = BOOLEAN;
              boolean_byte(b);
            end else begin
              acc   = '0;
              phase = NUMBER;
              number_byte(b);
            end
          end
        end
        NUMBER:  number_byte(b);
        BOOLEAN: boolean_byte(b);
        default: phase = WAIT_OPEN;
      endcase
    end
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    body_bytes.push_back(b);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed bodies with random content, salted with noise, broken
  // keys, odd bytes after keys and braces inside messages.
  function automatic void compose_body();
    int nfields;
    int sel;
    int k;
    int len;
    logic [7:0] c;
    body_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) append_byte(any_byte());
    end
    append_byte(CH_OPEN);
    nfields = $urandom_range(0, 4);
    for (int f = 0; f < nfields; f++) begin
      sel = $urandom_range(0, 9);
      if (sel <= 7) begin
        k = sel / 2;
        append_byte(CH_QUOTE);
        for (int i = 0; i < KEY_LEN[k]; i++) append_byte(KEY_TEXT[k][i]);
        append_byte(($urandom_range(0, 5) == 0) ? any_byte() : CH_QUOTE);
        repeat ($urandom_range(0, 3)) append_byte($urandom_range(0, 1) ? CH_COLON : CH_SPACE);
        if (4'(1 << k) == KEY_MSG) begin
          if ($urandom_range(0, 7) != 0) append_byte(CH_QUOTE);
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
          repeat (len) begin
            c = any_byte();
            append_byte((c == CH_QUOTE) ? "q" : c);
          end
          append_byte(CH_QUOTE);
          if ($urandom_range(0, 1)) append_byte(CH_COMMA);
        end else if (4'(1 << k) == KEY_BOOL) begin
          if ($urandom_range(0, 7) != 0) append_byte($urandom_range(0, 1) ? CH_TRUE : "f");
          repeat ($urandom_range(0, 4)) append_byte(8'("a" + $urandom_range(0, 25)));
          append_byte(($urandom_range(0, 3) == 0) ? CH_CLOSE : CH_COMMA);
        end else begin
          repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 7) == 0) append_byte(any_byte());
            else append_byte(8'(CH_ZERO + $urandom_range(0, 9)));
          end
          append_byte(($urandom_range(0, 3) == 0) ? CH_CLOSE : CH_COMMA);
        end
      end else if (sel == 8) begin
        k = $urandom_range(0, 3);
        append_byte(CH_QUOTE);
        len = $urandom_range(0, KEY_LEN[k] - 1);
        for (int i = 0; i < len; i++) append_byte(KEY_TEXT[k][i]);
        append_byte(any_byte());
      end else begin
        append_byte(any_byte());
      end
    end
    append_byte(CH_CLOSE);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_jitter ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    extract_fields(b);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (fields_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result receiver: a random stall before each item, independent of out_valid.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = out_jitter ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fields_due.size() == 0) begin
        $error("field_kind: nothing expected, got %0d (value %0h)", out_field_kind,
               out_field_value);
        failures++;
      end else begin
        want = fields_due.pop_front();
        if (out_field_kind !== want.kind) begin
          $error("field_kind: expected %0d, got %0d", want.kind, out_field_kind);
          failures++;
        end
        if (out_field_value !== want.value) begin
          $error("field_value: expected %0h, got %0h", want.value, out_field_value);
          failures++;
        end
        if (out_body_end !== want.body_end) begin
          $error("body_end: expected %0d, got %0d", want.body_end, out_body_end);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] limit_plan [PHASES];
    logic [7:0] new_limit;
    int         pushed_mark;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_jitter    = 1'b1;
    out_jitter   = 1'b1;
    failures     = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    fields_pushed = 0;
    msg_limit    = MAX_MSG_RESET;
    clear_parse(WAIT_OPEN);
    limit_plan = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd31};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      pushed_mark = fields_pushed;
      send_byte(DIRECTED_BYTES[i].b);
      if (DIRECTED_BYTES[i].typed) begin
        repeat (fields_pushed - pushed_mark) void'(fields_due.pop_back());
        if (DIRECTED_BYTES[i].n >= 2'd1) fields_due.push_back(DIRECTED_BYTES[i].first);
        if (DIRECTED_BYTES[i].n == 2'd2) fields_due.push_back(DIRECTED_BYTES[i].second);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      new_limit = (p == 4) ? 8'($urandom_range(0, 255)) : limit_plan[p];
      cfg_valid = 1'b1;
      cfg_data  = new_limit;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      msg_limit = new_limit;
      @(negedge clk);
      cfg_valid = 1'b0;
      while (items_sent < DIR_ROWS + RANDOM_ITEMS * (p + 1) / PHASES) begin
        in_jitter  = ($urandom_range(0, 3) != 0);
        out_jitter = ($urandom_range(0, 3) != 0);
        compose_body();
        foreach (body_bytes[i]) send_byte(body_bytes[i]);
      end
      // Leave the parser waiting for an opening brace before the next write.
      while (phase != WAIT_OPEN) send_byte((phase == MESSAGE) ? CH_QUOTE : CH_CLOSE);
    end

    wait_drained();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/jfkx_pkg.sv
hw/rtl/jfkx_parser.sv
hw/rtl/jfkx_result_queue.sv
hw/rtl/json_fixed_key_field_extractor.sv
verif/json_fixed_key_field_extractor_tb.sv
